[hdl/scalar_field_rhs_and_sources_defines.svh]
// ----------------------------------------------------------------------------
// scalar_field_rhs_and_sources assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SCALAR_FIELD_RHS_AND_SOURCES_DEFINES_SVH
`define SCALAR_FIELD_RHS_AND_SOURCES_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define SRS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SRS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define SRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[hdl/srs_pkg.sv]
// ----------------------------------------------------------------------------
// srs_pkg
// Types, constants and saturating fixed-point helpers for the scalar field
// right-hand side pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

    localparam int WORD_W     = 32;
    localparam int FRAC_W     = 24;
    localparam int WIDE_W     = 2 * WORD_W + 1;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = WORD_W / DIV_STEP;
    localparam int DIV_LAT    = DIV_STAGES + 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [4:0]        coef_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam word_t FX_ONE   = word_t'(64'sd1 << FRAC_W);

    localparam coef_t K_TWO   = 5'sd2;
    localparam coef_t K_THREE = 5'sd3;
    localparam coef_t K_FOUR  = 5'sd4;

    localparam logic [CFG_IDX_W-1:0] REG_DIM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CUT = 1'b1;
    localparam logic [3:0]           DIM_RESET = 4'd4;

    typedef struct packed {
        logic [63:0] field_values;
        logic [63:0] first_derivs;
        word_t       second_deriv_psi;
        logic [63:0] lapse_shift;
        logic [63:0] trace_k_chi;
        logic [63:0] metric_diag;
        logic [63:0] geometry_derivs;
        logic [63:0] christoffels;
        word_t       radius;
    } in_t;

    typedef struct packed {
        word_t rhs_psi;
        word_t rhs_k_psi;
        word_t energy_density;
        word_t momentum_density;
        word_t stress_zz;
        word_t stress_ww;
        logic  saturated;
    } out_t;

    typedef struct packed {
        logic  ovf;
        word_t val;
    } fx_t;

    function automatic fx_t fx_sat(input wide_t x);
        fx_t r;
        if (x > wide_t'(WORD_MAX)) begin
            r.ovf = 1'b1;
            r.val = WORD_MAX;
        end else if (x < wide_t'(WORD_MIN)) begin
            r.ovf = 1'b1;
            r.val = WORD_MIN;
        end else begin
            r.ovf = 1'b0;
            r.val = x[WORD_W-1:0];
        end
        return r;
    endfunction

    // product rounded to nearest, ties up
    function automatic fx_t fx_mul(input word_t a, input word_t b);
        logic signed [2*WORD_W-1:0] prod;
        wide_t p;
        prod = (2*WORD_W)'(a) * (2*WORD_W)'(b);
        p = wide_t'(prod) + (wide_t'(1) <<< (FRAC_W - 1));
        return fx_sat(p >>> FRAC_W);
    endfunction

    function automatic fx_t fx_add(input word_t a, input word_t b);
        return fx_sat(wide_t'(a) + wide_t'(b));
    endfunction

    function automatic fx_t fx_sub(input word_t a, input word_t b);
        return fx_sat(wide_t'(a) - wide_t'(b));
    endfunction

    function automatic fx_t fx_scale(input coef_t k, input word_t a);
        logic signed [WORD_W+4:0] p;
        p = (WORD_W+5)'(k) * (WORD_W+5)'(a);
        return fx_sat(wide_t'(p));
    endfunction

    function automatic word_t fx_half(input word_t a);
        logic signed [WORD_W:0] x;
        x = (WORD_W+1)'(a) + (WORD_W+1)'(1);
        return x[WORD_W:1];
    endfunction

    function automatic word_t fx_quarter(input word_t a);
        logic signed [WORD_W+1:0] x;
        x = (WORD_W+2)'(a) + (WORD_W+2)'(2);
        return x[WORD_W+1:2];
    endfunction

endpackage

`default_nettype wire

[hdl/srs_div.sv]
// ----------------------------------------------------------------------------
// srs_div
// Pipelined fixed-point divider, (num * 2^FRAC_W) / den truncated toward
// zero with saturation; DIV_STEP quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_div import srs_pkg::*; (
    input  logic  aclk,
    input  logic  en,
    input  word_t num,
    input  word_t den,
    output word_t quot,
    output logic  ovf
);

    localparam int REM_W = WORD_W + 1;
    localparam logic [WORD_W-1:0] MAG_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [WORD_W-1:0] bits;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] dvs;
        logic              neg;
        logic              zero;
        logic              big;
        logic              num_neg;
    } dstage_t;

    dstage_t prep_next;
    dstage_t stg_reg  [0:DIV_STAGES];
    dstage_t stg_next [1:DIV_STAGES];
    word_t   quot_reg, quot_next;
    logic    ovf_reg, ovf_next;

    always_comb begin
        logic [WORD_W-1:0] an;
        logic [WORD_W-1:0] bn;
        an = num[WORD_W-1] ? (~num + WORD_W'(1)) : num;
        bn = den[WORD_W-1] ? (~den + WORD_W'(1)) : den;
        prep_next.rem     = REM_W'(an >> (WORD_W - FRAC_W));
        prep_next.bits    = an << FRAC_W;
        prep_next.quo     = '0;
        prep_next.dvs     = bn;
        prep_next.neg     = num[WORD_W-1] ^ den[WORD_W-1];
        prep_next.zero    = (den == '0);
        prep_next.big     = (REM_W'(an >> (WORD_W - FRAC_W)) >= REM_W'(bn));
        prep_next.num_neg = num[WORD_W-1];
    end

    // restoring steps
    always_comb begin
        dstage_t cur;
        logic [REM_W-1:0] trial;
        for (int k = 1; k <= DIV_STAGES; k++) begin
            cur = stg_reg[k-1];
            for (int j = 0; j < DIV_STEP; j++) begin
                trial    = {cur.rem[WORD_W-1:0], cur.bits[WORD_W-1]};
                cur.bits = cur.bits << 1;
                if (trial >= {1'b0, cur.dvs}) begin
                    cur.rem = trial - {1'b0, cur.dvs};
                    cur.quo = {cur.quo[WORD_W-2:0], 1'b1};
                end else begin
                    cur.rem = trial;
                    cur.quo = {cur.quo[WORD_W-2:0], 1'b0};
                end
            end
            stg_next[k] = cur;
        end
    end

    always_comb begin
        dstage_t fin;
        fin = stg_reg[DIV_STAGES];
        ovf_next  = 1'b0;
        quot_next = fin.quo;
        if (fin.zero) begin
            ovf_next  = 1'b1;
            quot_next = fin.num_neg ? WORD_MIN : WORD_MAX;
        end else if (fin.big) begin
            ovf_next  = 1'b1;
            quot_next = fin.neg ? WORD_MIN : WORD_MAX;
        end else if (!fin.neg) begin
            if (fin.quo[WORD_W-1]) begin
                ovf_next  = 1'b1;
                quot_next = WORD_MAX;
            end
        end else begin
            if (fin.quo > MAG_MIN) begin
                ovf_next  = 1'b1;
                quot_next = WORD_MIN;
            end else begin
                quot_next = ~fin.quo + WORD_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stg_reg[0] <= prep_next;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                stg_reg[k] <= stg_next[k];
            end
            quot_reg <= quot_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign quot = quot_reg;
    assign ovf  = ovf_reg;

endmodule

`default_nettype wire

[hdl/srs_obuf.sv]
// ----------------------------------------------------------------------------
// srs_obuf
// Output register with a skid entry; the pipeline advances whenever the
// skid entry is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_obuf import srs_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic p_valid,
    input  out_t p_data,
    output logic p_en,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic out_valid_reg;
    logic skid_valid_reg;
    out_t out_data_reg;
    out_t skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_ready || !out_valid_reg) begin
            out_valid_reg  <= skid_valid_reg | p_valid;
            skid_valid_reg <= 1'b0;
        end else if (p_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : p_data;
        end else if (!skid_valid_reg) begin
            skid_data_reg <= p_data;
        end
    end

    assign p_en    = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

[hdl/scalar_field_rhs_and_sources.sv]
// ----------------------------------------------------------------------------
// scalar_field_rhs_and_sources
// Massless scalar field right-hand side and matter sources, one radial grid
// point per transfer, signed Q8.24 with saturation.
// ----------------------------------------------------------------------------
// One grid point is accepted per clock while s_ready is high. The pipeline
// has four unpack, multiply and add stages ahead of a bank of five pipelined
// dividers (four quotient bits a stage), nine multiply and add stages behind
// them, and the output register. s_ready drops only while a result waits in
// the output skid entry.
`default_nettype none
`include "scalar_field_rhs_and_sources_defines.svh"

module scalar_field_rhs_and_sources import srs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data
);

    localparam int PRE_N  = 4;
    localparam int POST_N = 9;
    localparam int VLD_N  = PRE_N + DIV_LAT + POST_N;
    localparam int NDIV   = 5;

    typedef struct packed {
        logic  flag;
        logic  zle;
        word_t kpsi, dpsi, dk, ddpsi, alpha, beta, trk, chi;
        word_t hzz, hww, dalpha, dchi, gzzz, gzww, z;
        word_t bd, ak, gz, gw, bk, at, k2, g2, kd;
        word_t cdzz, hk, k4, atk, hg2, k2x2, nzz, rk0;
        word_t hzi, hwi, q, s1, s2;
        word_t cdww, hzc, hzda, ahz, hzchi, hzg2;
        word_t hwc, hzdad, ahzc, eg, t5;
        word_t im, mt, mw, inner, tq, ai, qt, br, cb, rk;
        word_t v0, v1, v2, v3, v4, v5;
    } pt_t;

    logic [3:0]       dim_reg;
    word_t            cut_reg;
    logic [VLD_N-1:0] vld_reg;
    logic             en;
    coef_t            dim_m2, dim_m3;

    pt_t st0_next, st1_next, st2_next, st3_next;
    pt_t st0_reg, st1_reg, st2_reg, st3_reg;
    pt_t dly_reg [DIV_LAT];
    pt_t st4_next, st5_next, st6_next, st7_next, st8_next;
    pt_t st9_next, st10_next, st11_next, st12_next;
    pt_t st4_reg, st5_reg, st6_reg, st7_reg, st8_reg;
    pt_t st9_reg, st10_reg, st11_reg, st12_reg;

    word_t dv_num  [NDIV];
    word_t dv_den  [NDIV];
    word_t dv_quot [NDIV];
    logic  dv_ovf  [NDIV];
    out_t  p_data;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg <= DIM_RESET;
            cut_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DIM: dim_reg <= cfg_wr_data[3:0];
                REG_CUT: cut_reg <= cfg_wr_data[WORD_W-1:0];
                default: ;
            endcase
        end
    end

    assign dim_m2 = coef_t'({1'b0, dim_reg}) - K_TWO;
    assign dim_m3 = coef_t'({1'b0, dim_reg}) - K_THREE;

    // unpack, clamp chi
    always_comb begin
        st0_next        = '0;
        st0_next.kpsi   = s_data.field_values[31:0];
        st0_next.dpsi   = s_data.first_derivs[63:32];
        st0_next.dk     = s_data.first_derivs[31:0];
        st0_next.ddpsi  = s_data.second_deriv_psi;
        st0_next.alpha  = s_data.lapse_shift[63:32];
        st0_next.beta   = s_data.lapse_shift[31:0];
        st0_next.trk    = s_data.trace_k_chi[63:32];
        st0_next.chi    = s_data.trace_k_chi[31:0];
        st0_next.hzz    = s_data.metric_diag[63:32];
        st0_next.hww    = s_data.metric_diag[31:0];
        st0_next.dalpha = s_data.geometry_derivs[63:32];
        st0_next.dchi   = s_data.geometry_derivs[31:0];
        st0_next.gzzz   = s_data.christoffels[63:32];
        st0_next.gzww   = s_data.christoffels[31:0];
        st0_next.z      = s_data.radius;
        if (st0_next.chi <= word_t'(0)) begin
            st0_next.chi = word_t'(1);
        end
        st0_next.zle    = (s_data.radius <= cut_reg);
    end

    always_comb begin
        fx_t r [9];
        st1_next = st0_reg;
        r[0] = fx_mul(st0_reg.beta, st0_reg.dpsi);
        r[1] = fx_mul(st0_reg.alpha, st0_reg.kpsi);
        r[2] = fx_mul(st0_reg.gzzz, st0_reg.dpsi);
        r[3] = fx_mul(st0_reg.gzww, st0_reg.dpsi);
        r[4] = fx_mul(st0_reg.beta, st0_reg.dk);
        r[5] = fx_mul(st0_reg.alpha, st0_reg.trk);
        r[6] = fx_mul(st0_reg.kpsi, st0_reg.kpsi);
        r[7] = fx_mul(st0_reg.dpsi, st0_reg.dpsi);
        r[8] = fx_mul(st0_reg.kpsi, st0_reg.dpsi);
        st1_next.bd = r[0].val;
        st1_next.ak = r[1].val;
        st1_next.gz = r[2].val;
        st1_next.gw = r[3].val;
        st1_next.bk = r[4].val;
        st1_next.at = r[5].val;
        st1_next.k2 = r[6].val;
        st1_next.g2 = r[7].val;
        st1_next.kd = r[8].val;
        for (int i = 0; i < 9; i++) begin
            st1_next.flag = st1_next.flag | r[i].ovf;
        end
    end

    always_comb begin
        fx_t r [8];
        st2_next = st1_reg;
        r[0] = fx_scale(K_TWO, st1_reg.ak);
        r[1] = fx_sub(st1_reg.bd, r[0].val);
        r[2] = fx_sub(st1_reg.ddpsi, st1_reg.gz);
        r[3] = fx_mul(st1_reg.hzz, st1_reg.k2);
        r[4] = fx_scale(K_FOUR, st1_reg.k2);
        r[5] = fx_scale(K_TWO, st1_reg.kd);
        r[6] = fx_mul(st1_reg.at, st1_reg.kpsi);
        r[7] = fx_scale(K_TWO, st1_reg.k2);
        st2_next.v0   = r[1].val;
        st2_next.cdzz = r[2].val;
        st2_next.hk   = r[3].val;
        st2_next.k4   = r[4].val;
        st2_next.v3   = r[5].val;
        st2_next.atk  = r[6].val;
        st2_next.k2x2 = r[7].val;
        st2_next.hg2  = fx_half(st1_reg.g2);
        for (int i = 0; i < 8; i++) begin
            st2_next.flag = st2_next.flag | r[i].ovf;
        end
    end

    always_comb begin
        fx_t r [2];
        st3_next = st2_reg;
        r[0] = fx_scale(K_TWO, st2_reg.hk);
        r[1] = fx_add(st2_reg.bk, st2_reg.atk);
        st3_next.nzz  = r[0].val;
        st3_next.rk0  = r[1].val;
        st3_next.flag = st2_reg.flag | r[0].ovf | r[1].ovf;
    end

    // divider bank: 1/h_zz, 1/h_ww, dpsi/z, 2 h_zz K2 / chi, 4 K2 / chi
    assign dv_num[0] = FX_ONE;
    assign dv_den[0] = st3_reg.hzz;
    assign dv_num[1] = FX_ONE;
    assign dv_den[1] = st3_reg.hww;
    assign dv_num[2] = st3_reg.dpsi;
    assign dv_den[2] = st3_reg.z;
    assign dv_num[3] = st3_reg.nzz;
    assign dv_den[3] = st3_reg.chi;
    assign dv_num[4] = st3_reg.k4;
    assign dv_den[4] = st3_reg.chi;

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        srs_div u_div (
            .aclk (aclk),
            .en   (en),
            .num  (dv_num[g]),
            .den  (dv_den[g]),
            .quot (dv_quot[g]),
            .ovf  (dv_ovf[g])
        );
    end

    always_comb begin
        fx_t r [7];
        pt_t p;
        p = dly_reg[DIV_LAT-1];
        p.hzi  = dv_quot[0];
        p.hwi  = dv_quot[1];
        p.q    = p.zle ? p.ddpsi : dv_quot[2];
        p.s1   = dv_quot[3];
        p.s2   = dv_quot[4];
        p.flag = p.flag | dv_ovf[0] | dv_ovf[1] | (!p.zle & dv_ovf[2])
               | dv_ovf[3] | dv_ovf[4];
        st4_next = p;
        r[0] = fx_sub(p.q, p.gw);
        r[1] = fx_mul(p.hzi, p.cdzz);
        r[2] = fx_mul(p.hzi, p.dalpha);
        r[3] = fx_mul(p.alpha, p.hzi);
        r[4] = fx_mul(p.hzi, p.chi);
        r[5] = fx_mul(p.hzi, p.g2);
        r[6] = fx_add(p.hg2, p.s1);
        st4_next.cdww  = r[0].val;
        st4_next.hzc   = r[1].val;
        st4_next.hzda  = r[2].val;
        st4_next.ahz   = r[3].val;
        st4_next.hzchi = r[4].val;
        st4_next.hzg2  = r[5].val;
        st4_next.v4    = r[6].val;
        for (int i = 0; i < 7; i++) begin
            st4_next.flag = st4_next.flag | r[i].ovf;
        end
    end

    always_comb begin
        fx_t r [5];
        st5_next = st4_reg;
        r[0] = fx_mul(st4_reg.hwi, st4_reg.cdww);
        r[1] = fx_mul(st4_reg.hzda, st4_reg.dpsi);
        r[2] = fx_mul(st4_reg.ahz, st4_reg.dchi);
        r[3] = fx_mul(st4_reg.hzchi, st4_reg.g2);
        r[4] = fx_sub(st4_reg.hzg2, st4_reg.s2);
        st5_next.hwc   = r[0].val;
        st5_next.hzdad = r[1].val;
        st5_next.ahzc  = r[2].val;
        st5_next.eg    = r[3].val;
        st5_next.t5    = r[4].val;
        for (int i = 0; i < 5; i++) begin
            st5_next.flag = st5_next.flag | r[i].ovf;
        end
    end

    always_comb begin
        fx_t r [4];
        st6_next = st5_reg;
        r[0] = fx_scale(dim_m2, st5_reg.hwc);
        r[1] = fx_mul(st5_reg.ahzc, st5_reg.dpsi);
        r[2] = fx_add(st5_reg.k2x2, fx_half(st5_reg.eg));
        r[3] = fx_mul(st5_reg.hww, st5_reg.t5);
        st6_next.im = r[0].val;
        st6_next.mt = r[1].val;
        st6_next.v2 = r[2].val;
        st6_next.mw = r[3].val;
        for (int i = 0; i < 4; i++) begin
            st6_next.flag = st6_next.flag | r[i].ovf;
        end
    end

    always_comb begin
        fx_t r [2];
        st7_next = st6_reg;
        r[0] = fx_add(st6_reg.hzc, st6_reg.im);
        r[1] = fx_scale(dim_m3, st6_reg.mt);
        st7_next.inner = r[0].val;
        st7_next.tq    = r[1].val;
        st7_next.v5    = -fx_half(st6_reg.mw);
        st7_next.flag  = st6_reg.flag | r[0].ovf | r[1].ovf;
    end

    always_comb begin
        fx_t r;
        st8_next = st7_reg;
        r = fx_mul(st7_reg.alpha, st7_reg.inner);
        st8_next.ai   = r.val;
        st8_next.qt   = fx_quarter(st7_reg.tq);
        st8_next.flag = st7_reg.flag | r.ovf;
    end

    always_comb begin
        fx_t r;
        st9_next = st8_reg;
        r = fx_add(st8_reg.hzdad, st8_reg.ai);
        st9_next.br   = r.val;
        st9_next.flag = st8_reg.flag | r.ovf;
    end

    always_comb begin
        fx_t r;
        st10_next = st9_reg;
        r = fx_mul(st9_reg.chi, st9_reg.br);
        st10_next.cb   = r.val;
        st10_next.flag = st9_reg.flag | r.ovf;
    end

    always_comb begin
        fx_t r;
        st11_next = st10_reg;
        r = fx_sub(st10_reg.rk0, fx_half(st10_reg.cb));
        st11_next.rk   = r.val;
        st11_next.flag = st10_reg.flag | r.ovf;
    end

    always_comb begin
        fx_t r;
        st12_next = st11_reg;
        r = fx_add(st11_reg.rk, st11_reg.qt);
        st12_next.v1   = r.val;
        st12_next.flag = st11_reg.flag | r.ovf;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st0_reg    <= st0_next;
            st1_reg    <= st1_next;
            st2_reg    <= st2_next;
            st3_reg    <= st3_next;
            dly_reg[0] <= st3_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
            st4_reg  <= st4_next;
            st5_reg  <= st5_next;
            st6_reg  <= st6_next;
            st7_reg  <= st7_next;
            st8_reg  <= st8_next;
            st9_reg  <= st9_next;
            st10_reg <= st10_next;
            st11_reg <= st11_next;
            st12_reg <= st12_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[VLD_N-2:0], s_valid};
        end
    end

    assign p_data.rhs_psi          = st12_reg.v0;
    assign p_data.rhs_k_psi        = st12_reg.v1;
    assign p_data.energy_density   = st12_reg.v2;
    assign p_data.momentum_density = st12_reg.v3;
    assign p_data.stress_zz        = st12_reg.v4;
    assign p_data.stress_ww        = st12_reg.v5;
    assign p_data.saturated        = st12_reg.flag;

    srs_obuf u_obuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .p_valid (vld_reg[VLD_N-1]),
        .p_data  (p_data),
        .p_en    (en),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    assign s_ready = en;

    `SRS_ASSERT_IMPL(a_stall_has_result, aclk, aresetn, !s_ready, m_valid, "stall without result")
    `SRS_ASSERT_NEXT(a_stall_freezes, aclk, aresetn, !s_ready, $stable(vld_reg), "pipe moved in stall")
    `SRS_ASSERT_NEXT(a_skid_drains, aclk, aresetn, !s_ready && m_ready, s_ready, "skid not drained")

endmodule

`default_nettype wire
